@@ design/skd_pkg.sv @@
`default_nettype none

package skd_pkg;

  localparam int HASH_W  = 31;
  localparam int VALUE_W = 32;
  localparam int SLOT_W  = 6;

  localparam logic [HASH_W-1:0] MULT_START = 31'd63689;
  localparam logic [HASH_W-1:0] MULT_STEP  = 31'd378551;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_MISS     = 3'd1;
  localparam logic [2:0] ST_INSERTED = 3'd2;
  localparam logic [2:0] ST_REPLACED = 3'd3;
  localparam logic [2:0] ST_DELETED  = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  typedef struct packed {
    logic [1:0]         operation;
    logic [7:0]         key_byte;
    logic               key_last;
    logic [VALUE_W-1:0] value_in;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [VALUE_W-1:0] value_out;
    logic [SLOT_W-1:0]  slot;
  } rsp_t;

  // finished key from the hash unit
  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] id;
  } hash_key_t;

  // operation handed to the table sequencer
  typedef struct packed {
    logic               valid;
    logic [1:0]         operation;
    logic [HASH_W-1:0]  id;
    logic [VALUE_W-1:0] value;
  } tbl_cmd_t;

endpackage

`default_nettype wire

@@ design/skd_hash.sv @@
`default_nettype none

module skd_hash (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [7:0]            key_byte,
  input  wire logic                  key_last,
  output logic                       idle,
  output skd_pkg::hash_key_t         key
);

  typedef enum logic [1:0] {
    H_IDLE,
    H_MUL,
    H_ADD
  } state_t;

  state_t                          state;
  logic [skd_pkg::HASH_W-1:0]      hash;
  logic [skd_pkg::HASH_W-1:0]      mult;
  logic [skd_pkg::HASH_W-1:0]      prod;
  logic [7:0]                      byte_q;
  logic                            last_q;

  logic [skd_pkg::HASH_W-1:0]      op_a;
  logic [skd_pkg::HASH_W-1:0]      op_b;
  logic [2*skd_pkg::HASH_W-1:0]    mul_full;
  logic [skd_pkg::HASH_W-1:0]      mul_lo;
  logic [skd_pkg::HASH_W-1:0]      hash_next;

  // one multiplier: hash * mult first, then mult * step
  always_comb begin
    op_a = (state == H_MUL) ? hash : mult;
    op_b = (state == H_MUL) ? mult : skd_pkg::MULT_STEP;
  end

  assign mul_full  = op_a * op_b;
  assign mul_lo    = mul_full[skd_pkg::HASH_W-1:0];
  assign hash_next = prod + skd_pkg::HASH_W'(byte_q);

  assign idle      = (state == H_IDLE);
  assign key.valid = (state == H_ADD) && last_q;
  assign key.id    = hash_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      hash  <= '0;
      mult  <= skd_pkg::MULT_START;
    end else begin
      unique case (state)
        H_IDLE: begin
          if (start) begin
            byte_q <= key_byte;
            last_q <= key_last;
            state  <= H_MUL;
          end
        end
        H_MUL: begin
          prod  <= mul_lo;
          state <= H_ADD;
        end
        H_ADD: begin
          // restart the fold after the final byte
          if (last_q) begin
            hash <= '0;
            mult <= skd_pkg::MULT_START;
          end else begin
            hash <= hash_next;
            mult <= mul_lo;
          end
          state <= H_IDLE;
        end
        default: state <= H_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/skd_table.sv @@
`default_nettype none

module skd_table #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire skd_pkg::tbl_cmd_t   cmd,
  output logic                     idle,
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  output skd_pkg::rsp_t            rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int PW = $clog2(CAPACITY + 1);
  localparam int EW = 1 + skd_pkg::HASH_W + VALUE_BITS;
  localparam logic [PW-1:0] CAP_P  = PW'(CAPACITY);
  localparam logic [PW-1:0] CAP_M1 = PW'(CAPACITY - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_APPEND,
    S_PACK,
    S_DONE
  } state_t;

  // entry layout: {live, id, value}
  logic [EW-1:0]                mem [CAPACITY];
  logic [EW-1:0]                rd_data;
  logic                         we;
  logic [AW-1:0]                wa;
  logic [AW-1:0]                ra;
  logic [EW-1:0]                wd;

  state_t                       state;
  logic [PW-1:0]                ptr;
  logic [PW-1:0]                issue_idx;
  logic [PW-1:0]                w_idx;
  logic [AW-1:0]                data_idx;
  logic                         data_vld;
  logic [skd_pkg::HASH_W-1:0]   key;
  logic [1:0]                   op;
  logic [VALUE_BITS-1:0]        val;
  logic                         hit;
  logic [AW-1:0]                hit_idx;
  logic [VALUE_BITS-1:0]        hit_val;
  logic                         post;
  logic [AW-1:0]                track_idx;
  logic [AW-1:0]                moved;
  logic [2:0]                   res_status;
  logic [VALUE_BITS-1:0]        res_val;
  logic [AW-1:0]                res_slot;

  logic                         rd_live;
  logic [skd_pkg::HASH_W-1:0]   rd_id;
  logic [VALUE_BITS-1:0]        rd_val;
  logic                         issue_more;
  logic                         hit_now;
  logic [VALUE_BITS-1:0]        cmd_val;
  logic [skd_pkg::VALUE_W-1:0]  vout;
  logic [skd_pkg::SLOT_W-1:0]   slot_o;

  if (VALUE_BITS >= skd_pkg::VALUE_W) begin : g_vin_wide
    assign cmd_val = VALUE_BITS'(cmd.value);
    assign vout    = res_val[skd_pkg::VALUE_W-1:0];
  end else begin : g_vin_narrow
    assign cmd_val = cmd.value[VALUE_BITS-1:0];
    assign vout    = skd_pkg::VALUE_W'(res_val);
  end

  if (AW >= skd_pkg::SLOT_W) begin : g_slot_wide
    assign slot_o = res_slot[skd_pkg::SLOT_W-1:0];
  end else begin : g_slot_narrow
    assign slot_o = skd_pkg::SLOT_W'(res_slot);
  end

  assign rd_live    = rd_data[EW-1];
  assign rd_id      = rd_data[VALUE_BITS +: skd_pkg::HASH_W];
  assign rd_val     = rd_data[VALUE_BITS-1:0];
  assign issue_more = (issue_idx < ptr);
  assign hit_now    = data_vld && rd_live && (rd_id == key);
  assign ra         = issue_idx[AW-1:0];

  assign idle          = (state == S_IDLE);
  assign rsp_valid     = (state == S_DONE);
  assign rsp.status    = res_status;
  assign rsp.value_out = vout;
  assign rsp.slot      = slot_o;

  always_comb begin
    we = 1'b0;
    wa = ptr[AW-1:0];
    wd = {1'b1, key, val};
    unique case (state)
      S_DECIDE: begin
        if (hit && op == skd_pkg::OP_INSERT) begin
          we = 1'b1;
          wa = hit_idx;
        end else if (hit && op == skd_pkg::OP_DELETE) begin
          we = 1'b1;
          wa = hit_idx;
          wd = {1'b0, key, hit_val};
        end
      end
      S_APPEND: we = (ptr != CAP_P);
      S_PACK: begin
        if (data_vld && rd_live) begin
          we = 1'b1;
          wa = w_idx[AW-1:0];
          wd = rd_data;
        end
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ptr      <= '0;
      data_vld <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            key       <= cmd.id;
            op        <= cmd.operation;
            val       <= cmd_val;
            issue_idx <= '0;
            data_vld  <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit_now) begin
            hit      <= 1'b1;
            hit_idx  <= data_idx;
            hit_val  <= rd_val;
            data_vld <= 1'b0;
            state    <= S_DECIDE;
          end else if (!issue_more && !data_vld) begin
            hit   <= 1'b0;
            state <= S_DECIDE;
          end else begin
            data_vld <= issue_more;
            data_idx <= issue_idx[AW-1:0];
            if (issue_more) begin
              issue_idx <= issue_idx + PW'(1);
            end
          end
        end
        S_DECIDE: begin
          res_val  <= '0;
          res_slot <= hit ? hit_idx : '0;
          unique case (op)
            skd_pkg::OP_INSERT: begin
              if (hit) begin
                res_status <= skd_pkg::ST_REPLACED;
                state      <= S_DONE;
              end else if (ptr == CAP_P) begin
                // pack before the append
                issue_idx <= '0;
                data_vld  <= 1'b0;
                w_idx     <= '0;
                post      <= 1'b0;
                state     <= S_PACK;
              end else begin
                state <= S_APPEND;
              end
            end
            skd_pkg::OP_DELETE: begin
              res_status <= hit ? skd_pkg::ST_DELETED : skd_pkg::ST_MISS;
              state      <= S_DONE;
            end
            default: begin
              res_status <= hit ? skd_pkg::ST_HIT : skd_pkg::ST_MISS;
              res_val    <= hit ? hit_val : '0;
              state      <= S_DONE;
            end
          endcase
        end
        S_APPEND: begin
          if (ptr == CAP_P) begin
            res_status <= skd_pkg::ST_FULL;
            res_slot   <= '0;
            state      <= S_DONE;
          end else begin
            ptr <= ptr + PW'(1);
            if (ptr == CAP_M1) begin
              // table just filled: pack and follow the new entry
              track_idx <= ptr[AW-1:0];
              moved     <= ptr[AW-1:0];
              issue_idx <= '0;
              data_vld  <= 1'b0;
              w_idx     <= '0;
              post      <= 1'b1;
              state     <= S_PACK;
            end else begin
              res_status <= skd_pkg::ST_INSERTED;
              res_slot   <= ptr[AW-1:0];
              state      <= S_DONE;
            end
          end
        end
        S_PACK: begin
          if (!issue_more && !data_vld) begin
            ptr <= w_idx;
            if (post) begin
              res_status <= skd_pkg::ST_INSERTED;
              res_slot   <= moved;
              state      <= S_DONE;
            end else begin
              state <= S_APPEND;
            end
          end else begin
            if (data_vld && rd_live) begin
              w_idx <= w_idx + PW'(1);
              if (post && data_idx == track_idx) begin
                moved <= w_idx[AW-1:0];
              end
            end
            data_vld <= issue_more;
            data_idx <= issue_idx[AW-1:0];
            if (issue_more) begin
              issue_idx <= issue_idx + PW'(1);
            end
          end
        end
        S_DONE: begin
          if (rsp_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (issue_idx <= ptr))
    else $error("scan index ran past the append pointer");

  a_pack_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_PACK && data_vld) |-> (w_idx <= PW'(data_idx)))
    else $error("pack write overtook the read");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != skd_pkg::ST_HIT) |-> (rsp.value_out == '0))
    else $error("nonzero value on a result other than a hit");

  a_done_release: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_ready) |=> idle)
    else $error("sequencer did not return to idle after handoff");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res_status == skd_pkg::ST_INSERTED) |-> (ptr != '0))
    else $error("insert reported with an empty table");

endmodule

`default_nettype wire

@@ design/string_keyed_dictionary_table_core.sv @@
`default_nettype none

// String-keyed dictionary: key bytes arrive one request each and fold into a
// 31-bit RS hash; the request carrying key_last runs lookup, insert or delete
// against a CAPACITY-slot table held in a single-port-read memory. Each key
// byte is accepted and then makes two passes through the one shared 31x31
// multiplier. The final byte then adds a linear scan up to the append
// pointer, one slot per cycle through the memory read port. An insert that
// fills the table, or that finds it full, adds a compaction pass over the
// slots below the append pointer. No clearing pass follows reset: entries
// beyond the append pointer are never read. Results sit in an output
// register, so the next request is taken while a result waits.
module string_keyed_dictionary_table_core #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire skd_pkg::req_t  req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output skd_pkg::rsp_t       rsp
);

  logic                          hash_idle;
  skd_pkg::hash_key_t            hash_key;
  skd_pkg::tbl_cmd_t             cmd;
  logic                          tbl_idle;
  logic                          tbl_rsp_valid;
  logic                          tbl_rsp_ready;
  skd_pkg::rsp_t                 tbl_rsp;
  logic                          accept;
  logic [1:0]                    op_q;
  logic [skd_pkg::VALUE_W-1:0]   value_q;

  assign req_ready = hash_idle && tbl_idle;
  assign accept    = req_valid && req_ready;

  // hold operation and value until the key is folded
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= req.operation;
      value_q <= req.value_in;
    end
  end

  skd_hash u_hash (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .key_byte (req.key_byte),
    .key_last (req.key_last),
    .idle     (hash_idle),
    .key      (hash_key)
  );

  assign cmd.valid     = hash_key.valid;
  assign cmd.operation = op_q;
  assign cmd.id        = hash_key.id;
  assign cmd.value     = value_q;

  skd_table #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .idle      (tbl_idle),
    .rsp_valid (tbl_rsp_valid),
    .rsp_ready (tbl_rsp_ready),
    .rsp       (tbl_rsp)
  );

  assign tbl_rsp_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (tbl_rsp_valid && tbl_rsp_ready) begin
      rsp_valid <= 1'b1;
      rsp       <= tbl_rsp;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int TBL_SLOTS  = 64;
  localparam int KEY_COUNT  = 120;
  localparam int KEY_MAX    = 8;
  localparam int NOISE_KEY  = KEY_COUNT;
  localparam int HOLD_OFF   = 600;
  localparam int DRAIN_WAIT = 250;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  skd_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  skd_pkg::rsp_t rsp;

  string_keyed_dictionary_table_core #(
    .CAPACITY  (TBL_SLOTS),
    .VALUE_BITS(skd_pkg::VALUE_W)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always #10 clk = ~clk;

  // table shadow
  logic [skd_pkg::HASH_W-1:0]  run_hash = '0;
  logic [skd_pkg::HASH_W-1:0]  run_mult = skd_pkg::MULT_START;
  logic [skd_pkg::HASH_W-1:0]  tbl_id    [TBL_SLOTS];
  logic [skd_pkg::VALUE_W-1:0] tbl_value [TBL_SLOTS];
  bit                          tbl_live  [TBL_SLOTS];
  int                          tbl_fill = 0;

  skd_pkg::rsp_t expected_rsps [$];
  skd_pkg::req_t pending_reqs [$];

  logic [7:0] key_pool [KEY_COUNT+1][KEY_MAX];
  int         key_len  [KEY_COUNT+1];

  int   total_reqs = 0;
  int   accepted_reqs = 0;
  int   fail_count = 0;
  logic req_taken = 1'b0;
  int   send_gap = 0;
  int   send_idle_pct = 20;
  int   rsp_idle_pct = 20;
  int   stall_left = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;

  function automatic bit quiet_tail();
    return accepted_reqs * 100 > total_reqs * 85;
  endfunction

  function automatic int live_slot_of(logic [skd_pkg::HASH_W-1:0] id);
    for (int i = 0; i < tbl_fill; i++) begin
      if (tbl_live[i] && tbl_id[i] == id) return i;
    end
    return -1;
  endfunction

  // pack live entries to the bottom; return where slot track ended up
  function automatic int pack_table(int track);
    int w;
    int moved;
    w = 0;
    moved = track;
    for (int r = 0; r < tbl_fill; r++) begin
      if (tbl_live[r]) begin
        if (r == track) moved = w;
        tbl_id[w]    = tbl_id[r];
        tbl_value[w] = tbl_value[r];
        tbl_live[w]  = 1'b1;
        w++;
      end
    end
    for (int r = w; r < TBL_SLOTS; r++) tbl_live[r] = 1'b0;
    tbl_fill = w;
    return moved;
  endfunction

  task automatic predict_request(input skd_pkg::req_t r);
    logic [63:0]                wide;
    logic [skd_pkg::HASH_W-1:0] id;
    int                         hit;
    int                         s;
    skd_pkg::rsp_t              res;
    wide = 64'(run_hash) * 64'(run_mult) + 64'(r.key_byte);
    run_hash = wide[skd_pkg::HASH_W-1:0];
    wide = 64'(run_mult) * 64'(skd_pkg::MULT_STEP);
    run_mult = wide[skd_pkg::HASH_W-1:0];
    if (r.key_last) begin
      id = run_hash;
      run_hash = '0;
      run_mult = skd_pkg::MULT_START;
      hit = live_slot_of(id);
      res = '0;
      res.status = skd_pkg::ST_MISS;
      case (r.operation)
        skd_pkg::OP_INSERT: begin
          if (hit >= 0) begin
            tbl_value[hit] = r.value_in;
            res.status = skd_pkg::ST_REPLACED;
            res.slot = 6'(hit);
          end else begin
            if (tbl_fill >= TBL_SLOTS) void'(pack_table(TBL_SLOTS));
            if (tbl_fill >= TBL_SLOTS) begin
              res.status = skd_pkg::ST_FULL;
            end else begin
              s = tbl_fill;
              tbl_id[s]    = id;
              tbl_value[s] = r.value_in;
              tbl_live[s]  = 1'b1;
              tbl_fill     = s + 1;
              if (tbl_fill >= TBL_SLOTS) s = pack_table(s);
              res.status = skd_pkg::ST_INSERTED;
              res.slot = 6'(s);
            end
          end
        end
        skd_pkg::OP_DELETE: begin
          if (hit >= 0) begin
            tbl_live[hit] = 1'b0;
            res.status = skd_pkg::ST_DELETED;
            res.slot = 6'(hit);
          end
        end
        default: begin
          // the unused code behaves as a lookup
          if (hit >= 0) begin
            res.status = skd_pkg::ST_HIT;
            res.value_out = tbl_value[hit];
            res.slot = 6'(hit);
          end
        end
      endcase
      expected_rsps.push_back(res);
    end
  endtask

  task automatic queue_key(input int k, input logic [1:0] op, input logic [31:0] val);
    skd_pkg::req_t item;
    for (int i = 0; i < key_len[k]; i++) begin
      item.key_byte  = key_pool[k][i];
      item.key_last  = (i == key_len[k] - 1);
      // operation and value only matter on the last byte; scramble the rest
      item.operation = item.key_last ? op : 2'($urandom_range(0, 3));
      item.value_in  = item.key_last ? val : 32'($urandom());
      pending_reqs.push_back(item);
    end
  endtask

  task automatic set_key(input int k, input int len);
    key_len[k] = len;
    for (int i = 0; i < len; i++) key_pool[k][i] = 8'($urandom_range(0, 255));
  endtask

  initial begin
    int         mode;
    int         roll;
    int         k;
    int         base;
    int         seg;
    logic [1:0] op;
    key_len[0] = 1; key_pool[0][0] = 8'hFF;
    key_len[1] = 2; key_pool[1][0] = 8'h00; key_pool[1][1] = 8'h01;
    key_len[2] = 4;
    key_pool[2][0] = 8'h80; key_pool[2][1] = 8'h7F;
    key_pool[2][2] = 8'h55; key_pool[2][3] = 8'hAA;
    key_len[3] = 1; key_pool[3][0] = 8'h41;
    for (int i = 4; i < KEY_COUNT; i++) set_key(i, $urandom_range(1, 5));

    // directed: empty-table miss, insert/replace at the value extremes,
    // zero byte in a key, unused opcode, delete and delete of a dead entry
    queue_key(3, skd_pkg::OP_LOOKUP, 32'hFFFF_FFFF);
    queue_key(0, skd_pkg::OP_INSERT, 32'hFFFF_FFFF);
    queue_key(0, skd_pkg::OP_LOOKUP, 32'h0);
    queue_key(0, skd_pkg::OP_INSERT, 32'h0);
    queue_key(1, skd_pkg::OP_INSERT, 32'h1234_5678);
    queue_key(1, OP_UNUSED, 32'h0);
    queue_key(2, skd_pkg::OP_INSERT, 32'hA5A5_A5A5);
    queue_key(0, skd_pkg::OP_DELETE, 32'h0);
    queue_key(0, skd_pkg::OP_DELETE, 32'h0);
    queue_key(0, skd_pkg::OP_LOOKUP, 32'h0);
    queue_key(2, skd_pkg::OP_LOOKUP, 32'h0);
    queue_key(2, skd_pkg::OP_DELETE, 32'h0);

    seg = 0;
    while (pending_reqs.size() < 1400) begin
      mode = (seg == 0 || $urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2);
      seg++;
      if (mode == 3) begin
        // run of distinct inserts: fills the table, forces packing and full
        base = $urandom_range(0, KEY_COUNT - 5);
        for (int n = 0; n < 70; n++)
          queue_key(4 + (base + n) % (KEY_COUNT - 4), skd_pkg::OP_INSERT, $urandom());
      end else begin
        for (int n = 0; n < 25; n++) begin
          roll = $urandom_range(0, 99);
          k = $urandom_range(0, KEY_COUNT - 1);
          case (mode)
            0: op = roll < 70 ? skd_pkg::OP_INSERT :
                    roll < 90 ? skd_pkg::OP_LOOKUP : skd_pkg::OP_DELETE;
            1: op = roll < 55 ? skd_pkg::OP_DELETE :
                    roll < 80 ? skd_pkg::OP_LOOKUP : skd_pkg::OP_INSERT;
            default: op = roll < 40 ? skd_pkg::OP_INSERT :
                          roll < 75 ? skd_pkg::OP_LOOKUP :
                          roll < 95 ? skd_pkg::OP_DELETE : OP_UNUSED;
          endcase
          if ($urandom_range(0, 99) < 8) begin
            set_key(NOISE_KEY, $urandom_range(1, KEY_MAX));
            k = NOISE_KEY;
            op = 2'($urandom_range(0, 3));
          end
          queue_key(k, op, $urandom());
        end
      end
    end
    total_reqs = pending_reqs.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || req_valid) @(posedge clk);
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (req_taken && !quiet_tail() && $urandom_range(0, 99) < send_idle_pct)
        send_gap = $urandom_range(1, 8);
      if (send_gap != 0 || pending_reqs.size() == 0) begin
        if (send_gap != 0) send_gap--;
        req_valid <= 1'b0;
      end else begin
        req_valid <= 1'b1;
        req <= pending_reqs.pop_front();
      end
    end
  end

  // response acceptor
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else if (!hold_done && accepted_reqs >= total_reqs / 3) begin
      // long hold-off: let the block back up into its request side
      hold_done = 1'b1;
      hold_left = HOLD_OFF;
      rsp_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      rsp_ready <= 1'b0;
    end else if (!quiet_tail() && $urandom_range(0, 99) < rsp_idle_pct) begin
      stall_left = $urandom_range(0, 7);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    skd_pkg::rsp_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_valid && req_ready;
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          $error("response with no request outstanding: %p", rsp);
          fail_count++;
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            fail_count++;
          end
          if (rsp.value_out !== want.value_out) begin
            $error("value_out: expected %h, got %h", want.value_out, rsp.value_out);
            fail_count++;
          end
          if (rsp.slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, rsp.slot);
            fail_count++;
          end
        end
      end
      if (req_valid && req_ready) begin
        predict_request(req);
        accepted_reqs++;
        if (accepted_reqs % 150 == 0) begin
          // vary idling density, including stretches with none
          case ($urandom_range(0, 2))
            0: send_idle_pct = 0;
            1: send_idle_pct = 10;
            default: send_idle_pct = 35;
          endcase
          case ($urandom_range(0, 2))
            0: rsp_idle_pct = 0;
            1: rsp_idle_pct = 10;
            default: rsp_idle_pct = 35;
          endcase
        end
      end
    end
  end

endmodule
